### hdl/pulsar_fold_power_accumulator_top_defines.svh
// Assertion macros shared by the pulse profile accumulator RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef PULSAR_FOLD_POWER_ACCUMULATOR_TOP_DEFINES_SVH
`define PULSAR_FOLD_POWER_ACCUMULATOR_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PFPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PFPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/pfpa_pkg.sv
// Package of the pulse profile accumulator: sizes, codes and payload types.
// Used by every module of the block except pfpa_ram; depends on nothing.
`default_nettype none

package pfpa_pkg;

  localparam int unsigned MAX_BINS   = 4096;
  localparam int unsigned COUNT_BITS = 40;

  localparam int unsigned BIN_BITS  = $clog2(MAX_BINS);
  localparam int unsigned EFF_W     = $clog2(MAX_BINS + 1);
  localparam int unsigned FRAC_BITS = 32;
  localparam int unsigned PH_W      = BIN_BITS + FRAC_BITS;
  localparam int unsigned SPAN_W    = EFF_W + FRAC_BITS;

  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned RBIN_W    = 12;
  localparam int unsigned SUM_W     = 57;
  localparam int unsigned CNT_OUT_W = 40;
  localparam int unsigned MEAN_W    = 17;
  localparam int unsigned POW_W     = 17;
  localparam int unsigned IQ_W      = SAMPLE_W + 2;
  localparam int unsigned SQ_W      = 2 * IQ_W;
  localparam int unsigned IQ_OFS    = (1 << SAMPLE_W) - 1;

  localparam int unsigned NB_W          = 13;
  localparam int unsigned STEP_W        = 32;
  localparam int unsigned CFG_W         = 32;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned NUM_BINS_RST  = 1024;

  localparam int unsigned DIV_W  = (SUM_W > COUNT_BITS + MEAN_W - 1) ?
                                   SUM_W : COUNT_BITS + MEAN_W - 1;
  localparam int unsigned DCNT_W = $clog2(MEAN_W);

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_BINS   = 1'b0,
    CFG_PHASE_STEP = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] i_sample;
    logic [SAMPLE_W-1:0] q_sample;
    logic [RBIN_W-1:0]   read_bin;
  } in_item_t;

  typedef struct packed {
    logic [RBIN_W-1:0]    out_bin;
    logic [SUM_W-1:0]     bin_sum;
    logic [CNT_OUT_W-1:0] bin_count;
    logic [MEAN_W-1:0]    bin_mean;
    logic                 bin_empty;
  } out_item_t;

  typedef struct packed {
    logic [SUM_W-1:0]      sum;
    logic [COUNT_BITS-1:0] cnt;
  } bin_entry_t;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic s_bin;
    logic s_acc;
    logic s_wrap;
    logic r_load;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_is_read;
    logic clr_last;
    logic div_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

### hdl/pfpa_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; no package needed.
`default_nettype none

module pfpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/pfpa_ctrl.sv
// Sequencer of the pulse profile accumulator: clear pass, sample and read steps.
// Depends on pfpa_pkg and the assertion macro header.
`default_nettype none
`include "pulsar_fold_power_accumulator_top_defines.svh"

module pfpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pfpa_pkg::dp_sts_t sts_i,
  output pfpa_pkg::dp_cmd_t cmd_o
);
  import pfpa_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_SBIN  = 9'b000000100,
    S_SACC  = 9'b000001000,
    S_SWRAP = 9'b000010000,
    S_RRD   = 9'b000100000,
    S_RLOAD = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_RDONE = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.in_is_read ? S_RRD : S_SBIN;
        end
      end
      S_SBIN: begin
        cmd_o.s_bin = 1'b1;
        state_d     = S_SACC;
      end
      S_SACC: begin
        cmd_o.s_acc = 1'b1;
        state_d     = S_SWRAP;
      end
      S_SWRAP: begin
        cmd_o.s_wrap = 1'b1;
        state_d      = S_IDLE;
      end
      S_RRD: begin
        state_d = S_RLOAD;
      end
      S_RLOAD: begin
        cmd_o.r_load = 1'b1;
        state_d      = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_RDONE;
        end
      end
      S_RDONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `PFPA_ASSERT(a_no_accept_clear, (state_q == S_CLEAR) |-> !cmd_o.accept, "request during clear")
  `PFPA_ASSERT_NEXT(a_read_to_ram, in_valid_i && in_ready_o && sts_i.in_is_read, state_q == S_RRD, "read request not sent to memory")
  `PFPA_ASSERT_NEXT(a_load_to_idle, cmd_o.out_load, in_ready_o, "not ready after result load")

endmodule

`default_nettype wire

### hdl/pfpa_dp.sv
// Datapath of the pulse profile accumulator: config, phase, power, divider, output.
// Depends on pfpa_pkg and the assertion macro header; drives the bin memory.
`default_nettype none
`include "pulsar_fold_power_accumulator_top_defines.svh"

module pfpa_dp (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  pfpa_pkg::in_item_t                          in_data_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output pfpa_pkg::out_item_t                         out_data_o,
  input  logic                                        cfg_we_i,
  input  logic [pfpa_pkg::CFG_IDX_W-1:0]              cfg_index_i,
  input  logic [pfpa_pkg::CFG_W-1:0]                  cfg_data_i,
  input  pfpa_pkg::dp_cmd_t                           cmd_i,
  output pfpa_pkg::dp_sts_t                           sts_o,
  output logic                                        ram_we_o,
  output logic [pfpa_pkg::BIN_BITS-1:0]               ram_waddr_o,
  output logic [$bits(pfpa_pkg::bin_entry_t)-1:0]     ram_wdata_o,
  output logic [pfpa_pkg::BIN_BITS-1:0]               ram_raddr_o,
  input  logic [$bits(pfpa_pkg::bin_entry_t)-1:0]     ram_rdata_i
);
  import pfpa_pkg::*;

  logic [NB_W-1:0]       num_bins_q;
  logic [STEP_W-1:0]     phase_step_q;
  logic [EFF_W-1:0]      eff_bins;
  logic [SPAN_W-1:0]     span;
  logic [PH_W-1:0]       phase_q, phase0, phase_wrap;
  logic [SPAN_W-1:0]     psum_q;
  logic [BIN_BITS-1:0]   bin0, acc_bin, rb_addr;
  logic [BIN_BITS-1:0]   clr_q;
  in_item_t              in_q;
  logic signed [IQ_W-1:0] a_s, b_s;
  logic signed [SQ_W-1:0] a_sq, b_sq;
  logic [POW_W-1:0]      power_q;
  bin_entry_t            ent, new_ent;
  logic                  sat, rb_ok;
  logic [SUM_W-1:0]      sum_v, res_sum_q;
  logic [COUNT_BITS-1:0] cnt_v, res_cnt_q;
  logic [DIV_W-1:0]      rem_q, dvs_q;
  logic [MEAN_W-1:0]     quo_q;
  logic [DCNT_W-1:0]     dcnt_q;
  logic                  res_empty;
  logic                  out_valid_q;
  out_item_t             out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_bins_q   <= NB_W'(NUM_BINS_RST);
      phase_step_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_NUM_BINS:   num_bins_q   <= cfg_data_i[NB_W-1:0];
        CFG_PHASE_STEP: phase_step_q <= cfg_data_i[STEP_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (num_bins_q == '0) begin
      eff_bins = EFF_W'(1);
    end else if (32'(num_bins_q) > MAX_BINS) begin
      eff_bins = EFF_W'(MAX_BINS);
    end else begin
      eff_bins = EFF_W'(num_bins_q);
    end
  end

  assign span       = {eff_bins, {FRAC_BITS{1'b0}}};
  assign phase0     = (SPAN_W'(phase_q) >= span) ? '0 : phase_q;
  assign bin0       = phase0[PH_W-1:FRAC_BITS];
  assign acc_bin    = phase_q[PH_W-1:FRAC_BITS];
  assign phase_wrap = (psum_q >= span) ? PH_W'(psum_q - span) : PH_W'(psum_q);

  assign a_s  = $signed({1'b0, in_q.i_sample, 1'b0}) - $signed(IQ_W'(IQ_OFS));
  assign b_s  = $signed({1'b0, in_q.q_sample, 1'b0}) - $signed(IQ_W'(IQ_OFS));
  assign a_sq = a_s * a_s;
  assign b_sq = b_s * b_s;

  assign ent         = bin_entry_t'(ram_rdata_i);
  assign sat         = &ent.cnt;
  assign new_ent.sum = ent.sum + SUM_W'(power_q);
  assign new_ent.cnt = ent.cnt + COUNT_BITS'(1);

  assign rb_ok   = 32'(in_q.read_bin) < MAX_BINS;
  assign rb_addr = BIN_BITS'(in_q.read_bin);
  assign sum_v   = rb_ok ? ent.sum : '0;
  assign cnt_v   = rb_ok ? ent.cnt : '0;

  assign ram_we_o    = cmd_i.clr_step || (cmd_i.s_acc && !sat);
  assign ram_waddr_o = cmd_i.clr_step ? clr_q : acc_bin;
  assign ram_wdata_o = cmd_i.clr_step ? '0 : new_ent;
  assign ram_raddr_o = cmd_i.s_bin ? bin0 : rb_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      clr_q   <= '0;
      dcnt_q  <= '0;
    end else begin
      if (cmd_i.s_bin) begin
        phase_q <= phase0;
      end else if (cmd_i.s_wrap) begin
        phase_q <= phase_wrap;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + BIN_BITS'(1);
      end
      if (cmd_i.r_load) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      in_q <= in_data_i;
    end
    if (cmd_i.s_bin) begin
      power_q <= a_sq[POW_W-1:0] + b_sq[POW_W-1:0];
    end
    if (cmd_i.s_acc) begin
      psum_q <= SPAN_W'(phase_q) + SPAN_W'(phase_step_q);
    end
    if (cmd_i.r_load) begin
      res_sum_q <= sum_v;
      res_cnt_q <= cnt_v;
      rem_q     <= DIV_W'(sum_v);
      dvs_q     <= DIV_W'(cnt_v) << (MEAN_W - 1);
      quo_q     <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_q >= dvs_q) begin
        rem_q <= rem_q - dvs_q;
        quo_q <= {quo_q[MEAN_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[MEAN_W-2:0], 1'b0};
      end
      dvs_q <= dvs_q >> 1;
    end
  end

  assign res_empty = (res_cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.out_bin   <= in_q.read_bin;
      out_q.bin_sum   <= res_sum_q;
      out_q.bin_count <= CNT_OUT_W'(res_cnt_q);
      out_q.bin_mean  <= res_empty ? '0 : quo_q;
      out_q.bin_empty <= res_empty;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.in_is_read = (in_data_i.kind == KIND_READ);
  assign sts_o.clr_last   = (clr_q == BIN_BITS'(MAX_BINS - 1));
  assign sts_o.div_last   = (dcnt_q == DCNT_W'(MEAN_W - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  `PFPA_ASSERT(a_wrap_in_span, cmd_i.s_wrap |-> (SPAN_W'(phase_wrap) < span), "phase outside span")
  `PFPA_ASSERT(a_div_rem, cmd_i.out_load && !res_empty |-> (rem_q < DIV_W'(res_cnt_q)), "divider remainder not below count")

endmodule

`default_nettype wire

### hdl/pulsar_fold_power_accumulator_top.sv
// Pulse profile accumulator: folds I/Q sample power into phase bins and reads
// bins back with their mean. After reset a clearing pass writes every bin to
// zero, one bin a cycle, MAX_BINS (4096) bins in all, and no request is
// accepted until it ends; configuration writes are taken at any time. A sample
// request then steps through accept, bin select and memory read, accumulate
// and write back, and phase wrap, for the read-modify-write on the single bin
// memory. A read request steps through accept, memory read, load, 17 divider
// steps at one quotient bit per cycle, and result load once the output is free;
// the result waits in an output register while the next requests are accepted.
// Depends on pfpa_pkg, pfpa_ctrl, pfpa_dp and pfpa_ram.
`default_nettype none

module pulsar_fold_power_accumulator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pfpa_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pfpa_pkg::out_item_t            out_data_o,
  input  logic                           cfg_we_i,
  input  logic [pfpa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pfpa_pkg::CFG_W-1:0]     cfg_data_i
);
  import pfpa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  logic                          ram_we;
  logic [BIN_BITS-1:0]           ram_waddr, ram_raddr;
  logic [$bits(bin_entry_t)-1:0] ram_wdata, ram_rdata;

  pfpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfpa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  pfpa_ram #(
    .WIDTH ($bits(bin_entry_t)),
    .DEPTH (MAX_BINS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire
